FILE: sv/soc_pkg.sv
// Shared types and constants for the substring occurrence counter.
// No dependencies; imported by every module of the block.
package soc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int COUNT_W     = 16;
  localparam int HOLD_W      = 4;

  typedef logic [MAX_PATTERN-1:0][7:0] window_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_CASE_FOLD    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic               match_end;
    logic [COUNT_W-1:0] occurrences;
    logic               count_saturated;
    logic               text_done;
  } out_t;

  // pattern settings as seen by the comparator; len is already clamped
  typedef struct packed {
    window_t          pattern;
    logic [LEN_W-1:0] len;
    logic             case_fold;
  } match_cfg_t;

endpackage

FILE: sv/substring_occurrence_counter_unit.sv
// Top level of the non-overlapping substring occurrence counter.
// Depends on soc_pkg, soc_window and soc_compare.
//
// Usage:
//   in  channel: one text byte per request (data_byte, end_of_text).
//   out channel: one result per request: match_end, running occurrences,
//                count_saturated and text_done (echo of end_of_text).
//   cfg port   : cfg_write/cfg_index/cfg_data set pattern bytes 0-7,
//                bytes 8-15, pattern length (0 disables, >16 acts as 16)
//                and case folding. Write only while the block is idle.
// The result is registered at the accepting edge. Throughput is one byte
// per cycle while results are taken; the window compare is done across
// all 16 lanes in parallel in the accept cycle.
// A single output register decouples the sides: in_ready stays high while
// the result register is empty or is being taken, so a stalled receiver
// holds the current result and blocks only the next request.
// A request with end_of_text set returns the final count and then clears
// the window, holdoff, count and saturation flag for the next text.
// Reset clears all configuration and text state and empties the output.
module substring_occurrence_counter_unit
  import soc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_write,
  input  reg_index_t cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]        pattern_low;
  logic [63:0]        pattern_high;
  logic [LEN_W-1:0]   pattern_length;
  logic               case_fold;

  logic [HOLD_W-1:0]  holdoff;
  logic [COUNT_W-1:0] total;
  logic               saturated;

  logic [HOLD_W-1:0]  holdoff_next;
  logic [COUNT_W-1:0] total_next;
  logic               saturated_next;
  logic               hit_next;

  logic               accept;
  window_t            window_next;
  logic [LEN_W-1:0]   seen_next;
  match_cfg_t         mcfg;
  logic               lanes_hit;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      case_fold      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        REG_CASE_FOLD:    case_fold      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mcfg.pattern   = window_t'({pattern_high, pattern_low});
    mcfg.case_fold = case_fold;
    if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      mcfg.len = LEN_W'(MAX_PATTERN);
    end else begin
      mcfg.len = pattern_length;
    end
  end

  soc_window u_window (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .clear       (in_data.end_of_text),
    .data_byte   (in_data.data_byte),
    .window_next (window_next),
    .seen_next   (seen_next)
  );

  soc_compare u_compare (
    .cfg    (mcfg),
    .window (window_next),
    .seen   (seen_next),
    .hit    (lanes_hit)
  );

  // holdoff blocks any match that overlaps the last counted occurrence
  always_comb begin
    holdoff_next   = holdoff;
    total_next     = total;
    saturated_next = saturated;
    hit_next       = 1'b0;
    if (holdoff != '0) begin
      holdoff_next = holdoff - HOLD_W'(1);
    end else if (lanes_hit) begin
      hit_next     = 1'b1;
      holdoff_next = HOLD_W'(mcfg.len - LEN_W'(1));
      if (total == '1) begin
        saturated_next = 1'b1;
      end else begin
        total_next = total + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff   <= '0;
      total     <= '0;
      saturated <= 1'b0;
    end else if (accept) begin
      if (in_data.end_of_text) begin
        holdoff   <= '0;
        total     <= '0;
        saturated <= 1'b0;
      end else begin
        holdoff   <= holdoff_next;
        total     <= total_next;
        saturated <= saturated_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.match_end       <= hit_next;
      out_data.occurrences     <= total_next;
      out_data.count_saturated <= saturated_next;
      out_data.text_done       <= in_data.end_of_text;
    end
  end

endmodule

FILE: sv/soc_window.sv
// Byte window of the counter: last MAX_PATTERN bytes, newest at lane 0,
// plus the count of bytes seen in this text, capped at MAX_PATTERN. Depends on soc_pkg.
module soc_window
  import soc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             clear,
  input  logic [7:0]       data_byte,
  output window_t          window_next,
  output logic [LEN_W-1:0] seen_next
);

  window_t          window;
  logic [LEN_W-1:0] seen;

  always_comb begin
    window_next = {window[MAX_PATTERN-2:0], data_byte};
    if (seen < LEN_W'(MAX_PATTERN)) begin
      seen_next = seen + LEN_W'(1);
    end else begin
      seen_next = seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      seen   <= '0;
    end else if (advance) begin
      if (clear) begin
        window <= '0;
        seen   <= '0;
      end else begin
        window <= window_next;
        seen   <= seen_next;
      end
    end
  end

endmodule

FILE: sv/soc_compare.sv
// Parallel comparator: checks every active window lane against its
// pattern byte, with optional ASCII case folding. Depends on soc_pkg.
module soc_compare
  import soc_pkg::*;
(
  input  match_cfg_t       cfg,
  input  window_t          window,
  input  logic [LEN_W-1:0] seen,
  output logic             hit
);

  function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  logic [MAX_PATTERN-1:0] lane_ok;

  // lane w holds the byte that pattern byte len-1-w must equal
  always_comb begin
    logic [LEN_W-1:0] pidx;
    for (int w = 0; w < MAX_PATTERN; w++) begin
      pidx = cfg.len - LEN_W'(1) - LEN_W'(w);
      if (LEN_W'(w) < cfg.len) begin
        lane_ok[w] = fold(cfg.pattern[pidx[HOLD_W-1:0]], cfg.case_fold)
                     == fold(window[w], cfg.case_fold);
      end else begin
        lane_ok[w] = 1'b1;
      end
    end
  end

  assign hit = (cfg.len != '0) && (seen >= cfg.len) && (&lane_ok);

endmodule
